// File: rtl/core/dqb_pkg.sv
// Shared types, constants, quantizer tables and cosine basis for the 8x8 DCT quantizer.
`default_nettype none

package dqb_pkg;

  localparam int COS_FRAC_BITS_DEFAULT = 14;
  localparam int SAMPLE_WIDTH          = 9;
  localparam int COEF_WIDTH            = 9;
  localparam int POS_WIDTH             = 6;
  localparam int TAP_WIDTH             = 3;
  localparam int Q_ENTRY_WIDTH         = 7;
  localparam int OFFSET_WIDTH          = 10;
  localparam int QUANT_WIDTH           = 11;
  localparam int MAG_WIDTH             = 14;
  localparam int STEP_WIDTH            = 4;
  localparam int CFG_INDEX_WIDTH       = 1;
  localparam logic [OFFSET_WIDTH-1:0] OFFSET_RESET = 10'd40;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_USE_CHROMA     = 1'b0,
    CFG_QUALITY_OFFSET = 1'b1
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_COLLECT,
    ST_ROW_MAC,
    ST_ROW_DRAIN,
    ST_ROW_WRITE,
    ST_COL_MAC,
    ST_COL_DRAIN,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                 row_pass;
    logic                 mac_issue;
    logic                 mac_first;
    logic [POS_WIDTH-1:0] k;
    logic [TAP_WIDTH-1:0] j;
    logic                 sample_wr;
    logic                 row_wr;
    logic                 div_load;
    logic                 div_step;
  } dp_cmd_t;

  // 0.5*cos(a*pi/16) with 30 fraction bits, a = 0..8
  localparam longint HALF_COS30 [9] = '{
    64'd536870912, 64'd526555088, 64'd496004047, 64'd446391850, 64'd379625062,
    64'd298269498, 64'd205451603, 64'd104738319, 64'd0
  };

  localparam logic [Q_ENTRY_WIDTH-1:0] LUMA_Q [64] = '{
    7'd16, 7'd11, 7'd10, 7'd16, 7'd24, 7'd40, 7'd51, 7'd61,
    7'd12, 7'd12, 7'd14, 7'd19, 7'd26, 7'd58, 7'd60, 7'd55,
    7'd14, 7'd13, 7'd16, 7'd24, 7'd40, 7'd57, 7'd69, 7'd56,
    7'd14, 7'd17, 7'd22, 7'd29, 7'd51, 7'd87, 7'd80, 7'd62,
    7'd18, 7'd22, 7'd37, 7'd56, 7'd68, 7'd109, 7'd103, 7'd77,
    7'd24, 7'd35, 7'd55, 7'd64, 7'd81, 7'd104, 7'd113, 7'd92,
    7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
    7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99
  };

  localparam logic [Q_ENTRY_WIDTH-1:0] CHROMA_Q [64] = '{
    7'd17, 7'd18, 7'd24, 7'd47, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd18, 7'd21, 7'd26, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd24, 7'd26, 7'd56, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd47, 7'd66, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99,
    7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99, 7'd99
  };

  // Basis entry C[u][x] for idx = u*8+x, rounded half away from zero to frac_bits.
  function automatic longint cos_value(input int frac_bits, input logic [5:0] idx);
    int     u;
    int     x;
    int     a;
    longint mag;
    longint r;
    logic   neg;
    begin
      u   = int'(idx[5:3]);
      x   = int'(idx[2:0]);
      a   = ((2 * x + 1) * u) % 32;
      neg = 1'b0;
      if (u == 0) begin
        mag = HALF_COS30[4];
      end else if (a <= 8) begin
        mag = HALF_COS30[a];
      end else if (a <= 16) begin
        mag = HALF_COS30[16 - a];
        neg = 1'b1;
      end else if (a <= 24) begin
        mag = HALF_COS30[a - 16];
        neg = 1'b1;
      end else begin
        mag = HALF_COS30[32 - a];
      end
      r = (mag + (longint'(1) << (29 - frac_bits))) >>> (30 - frac_bits);
      return neg ? -r : r;
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/dqb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dqb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: rtl/core/dqb_ctrl.sv
// Sequencer for sample collection, row pass, column pass, division and output.
`default_nettype none

module dqb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output dqb_pkg::dp_cmd_t      cmd
);

  dqb_pkg::state_t                      state;
  dqb_pkg::state_t                      state_next;
  logic [dqb_pkg::POS_WIDTH-1:0]        k;
  logic [dqb_pkg::TAP_WIDTH-1:0]        j;
  logic [dqb_pkg::STEP_WIDTH-1:0]       step;
  logic                                 k_last;
  logic                                 j_last;
  logic                                 in_beat;
  logic                                 out_beat;

  assign k_last   = (k == {dqb_pkg::POS_WIDTH{1'b1}});
  assign j_last   = (j == {dqb_pkg::TAP_WIDTH{1'b1}});
  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      dqb_pkg::ST_COLLECT: begin
        if (in_beat && k_last) state_next = dqb_pkg::ST_ROW_MAC;
      end
      dqb_pkg::ST_ROW_MAC: begin
        if (j_last) state_next = dqb_pkg::ST_ROW_DRAIN;
      end
      dqb_pkg::ST_ROW_DRAIN: begin
        if (step == dqb_pkg::STEP_WIDTH'(1)) state_next = dqb_pkg::ST_ROW_WRITE;
      end
      dqb_pkg::ST_ROW_WRITE: begin
        state_next = k_last ? dqb_pkg::ST_COL_MAC : dqb_pkg::ST_ROW_MAC;
      end
      dqb_pkg::ST_COL_MAC: begin
        if (j_last) state_next = dqb_pkg::ST_COL_DRAIN;
      end
      dqb_pkg::ST_COL_DRAIN: begin
        if (step == dqb_pkg::STEP_WIDTH'(1)) state_next = dqb_pkg::ST_DIV_LOAD;
      end
      dqb_pkg::ST_DIV_LOAD: begin
        state_next = dqb_pkg::ST_DIV_RUN;
      end
      dqb_pkg::ST_DIV_RUN: begin
        if (step == dqb_pkg::STEP_WIDTH'(dqb_pkg::MAG_WIDTH - 1)) state_next = dqb_pkg::ST_EMIT;
      end
      dqb_pkg::ST_EMIT: begin
        if (out_beat) state_next = k_last ? dqb_pkg::ST_COLLECT : dqb_pkg::ST_COL_MAC;
      end
      default: state_next = dqb_pkg::ST_COLLECT;
    endcase
  end

  always_comb begin
    in_stall      = (state != dqb_pkg::ST_COLLECT);
    out_valid     = (state == dqb_pkg::ST_EMIT);
    cmd.row_pass  = (state == dqb_pkg::ST_ROW_MAC);
    cmd.mac_issue = (state == dqb_pkg::ST_ROW_MAC) || (state == dqb_pkg::ST_COL_MAC);
    cmd.mac_first = (j == '0);
    cmd.k         = k;
    cmd.j         = j;
    cmd.sample_wr = (state == dqb_pkg::ST_COLLECT) && in_valid;
    cmd.row_wr    = (state == dqb_pkg::ST_ROW_WRITE);
    cmd.div_load  = (state == dqb_pkg::ST_DIV_LOAD);
    cmd.div_step  = (state == dqb_pkg::ST_DIV_RUN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dqb_pkg::ST_COLLECT;
      k     <= '0;
      j     <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      // advance element index on each sample, row write and output beat
      if (in_beat || (state == dqb_pkg::ST_ROW_WRITE) || out_beat) begin
        k <= k + 1'b1;
      end
      j    <= cmd.mac_issue ? j + 1'b1 : '0;
      step <= (state_next != state) ? '0 : step + 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dqb_datapath.sv
// Buffers, shared multiply-accumulate, serial divider and configuration registers.
`default_nettype none

module dqb_datapath #(
  parameter int COS_FRAC_BITS = dqb_pkg::COS_FRAC_BITS_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire dqb_pkg::dp_cmd_t                      cmd,
  input  wire logic signed [dqb_pkg::SAMPLE_WIDTH-1:0] sample,
  input  wire logic                                  cfg_valid,
  input  wire logic [dqb_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  wire logic [dqb_pkg::OFFSET_WIDTH-1:0]      cfg_data,
  output logic signed [dqb_pkg::COEF_WIDTH-1:0]      coefficient,
  output logic [dqb_pkg::POS_WIDTH-1:0]              position,
  output logic                                       last_of_block
);

  localparam int COS_W  = COS_FRAC_BITS + 1;
  localparam int ROW_W  = COS_FRAC_BITS + 12;
  localparam int PROD_W = ROW_W + COS_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int SW     = dqb_pkg::SAMPLE_WIDTH;
  localparam int QW     = dqb_pkg::QUANT_WIDTH;
  localparam int MW     = dqb_pkg::MAG_WIDTH;

  logic                             use_chroma;
  logic [dqb_pkg::OFFSET_WIDTH-1:0] quality_offset;

  logic [SW-1:0]              sample_rdata;
  logic [ROW_W-1:0]           row_rdata;
  logic [5:0]                 cos_idx;
  logic signed [63:0]         cos_full;
  logic signed [COS_W-1:0]    s1_cos;
  logic                       s1_mac;
  logic                       s1_first;
  logic                       s1_row;
  logic signed [ROW_W-1:0]    mul_a;
  logic signed [PROD_W-1:0]   prod;
  logic                       s2_mac;
  logic                       s2_first;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    prod_ext;

  logic [ACC_W-1:0]           acc_abs;
  logic [dqb_pkg::Q_ENTRY_WIDTH-1:0] q_entry;
  logic [QW-1:0]              q_sum;
  logic [QW-1:0]              dv_q;
  logic [QW-1:0]              dv_rem;
  logic [MW-1:0]              dv_quo;
  logic                       dv_neg;
  logic [QW:0]                dv_shift;
  logic                       dv_ge;
  logic [QW:0]                dv_diff;
  logic [SW-1:0]              quo_neg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      use_chroma     <= 1'b0;
      quality_offset <= dqb_pkg::OFFSET_RESET;
    end else if (cfg_valid) begin
      unique case (dqb_pkg::cfg_index_t'(cfg_index))
        dqb_pkg::CFG_USE_CHROMA:     use_chroma     <= cfg_data[0];
        dqb_pkg::CFG_QUALITY_OFFSET: quality_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  dqb_ram #(.WIDTH(SW), .DEPTH(64)) u_sample_ram (
    .clk     (clk),
    .wr_en   (cmd.sample_wr),
    .wr_addr (cmd.k),
    .wr_data (sample),
    .rd_addr ({cmd.k[5:3], cmd.j}),
    .rd_data (sample_rdata)
  );

  dqb_ram #(.WIDTH(ROW_W), .DEPTH(64)) u_row_ram (
    .clk     (clk),
    .wr_en   (cmd.row_wr),
    .wr_addr (cmd.k),
    .wr_data (acc[ROW_W-1:0]),
    .rd_addr ({cmd.j, cmd.k[2:0]}),
    .rd_data (row_rdata)
  );

  // row pass: C[v][j], column pass: C[u][i]
  assign cos_idx  = cmd.row_pass ? {cmd.k[2:0], cmd.j} : {cmd.k[5:3], cmd.j};
  assign cos_full = dqb_pkg::cos_value(COS_FRAC_BITS, cos_idx);

  assign mul_a    = s1_row ? {{(ROW_W-SW){sample_rdata[SW-1]}}, sample_rdata}
                           : $signed(row_rdata);
  assign prod_ext = {prod[PROD_W-1], prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_mac <= 1'b0;
      s2_mac <= 1'b0;
    end else begin
      s1_mac <= cmd.mac_issue;
      s2_mac <= s1_mac;
    end
  end

  always_ff @(posedge clk) begin
    s1_cos   <= cos_full[COS_W-1:0];
    s1_first <= cmd.mac_first;
    s1_row   <= cmd.row_pass;
    prod     <= mul_a * s1_cos;
    s2_first <= s1_first;
    if (s2_mac) begin
      acc <= s2_first ? prod_ext : acc + prod_ext;
    end
  end

  // divider: truncate |S| >> 2F, then divide by q plus the quality offset one quotient bit per cycle
  assign acc_abs  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign q_entry  = use_chroma ? dqb_pkg::CHROMA_Q[cmd.k] : dqb_pkg::LUMA_Q[cmd.k];
  assign q_sum    = {{(QW-dqb_pkg::Q_ENTRY_WIDTH){1'b0}}, q_entry}
                  + {{(QW-dqb_pkg::OFFSET_WIDTH){1'b0}}, quality_offset};
  assign dv_shift = {dv_rem, dv_quo[MW-1]};
  assign dv_ge    = (dv_shift >= {1'b0, dv_q});
  assign dv_diff  = dv_shift - {1'b0, dv_q};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dv_q   <= q_sum;
      dv_rem <= '0;
      dv_quo <= acc_abs[2*COS_FRAC_BITS +: MW];
      dv_neg <= acc[ACC_W-1];
    end else if (cmd.div_step) begin
      dv_rem <= dv_ge ? dv_diff[QW-1:0] : dv_shift[QW-1:0];
      dv_quo <= {dv_quo[MW-2:0], dv_ge};
    end
  end

  assign quo_neg = SW'(-dv_quo[SW-1:0]);

  always_comb begin
    if (dv_neg) begin
      coefficient = (dv_quo > MW'(256)) ? -9'sd256 : $signed(quo_neg);
    end else begin
      coefficient = (dv_quo > MW'(255)) ? 9'sd255 : $signed(dv_quo[SW-1:0]);
    end
  end

  assign position      = cmd.k;
  assign last_of_block = (cmd.k == {dqb_pkg::POS_WIDTH{1'b1}});

endmodule

`default_nettype wire

// File: rtl/core/dct8x8_quantize_block.sv
// Top level of the 8x8 forward DCT and quantizer.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------------
//   input   | in        | in_valid / in_stall  | sample
//   output  | out       | out_valid / out_stall| coefficient, position, last_of_block
//   config  | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// 64 input beats are taken one per cycle, then the block stalls its input for
// the transform: a row pass over all 64 elements, then a column pass in which each
// coefficient is accumulated, divided and held until the output takes it. One shared
// multiplier (one tap per cycle) and a one-bit-per-cycle divider set the block's pace.
// Synchronous reset returns to sample collection; buffers need no clearing.
// An output stall holds the current coefficient and halts the sequencer.
`default_nettype none

module dct8x8_quantize_block #(
  parameter int COS_FRAC_BITS = dqb_pkg::COS_FRAC_BITS_DEFAULT
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic signed [dqb_pkg::SAMPLE_WIDTH-1:0] sample,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic signed [dqb_pkg::COEF_WIDTH-1:0]        coefficient,
  output logic [dqb_pkg::POS_WIDTH-1:0]                position,
  output logic                                         last_of_block,
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [dqb_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  wire logic [dqb_pkg::OFFSET_WIDTH-1:0]        cfg_data
);

  dqb_pkg::dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  dqb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  dqb_datapath #(.COS_FRAC_BITS(COS_FRAC_BITS)) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sample        (sample),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .coefficient   (coefficient),
    .position      (position),
    .last_of_block (last_of_block)
  );

endmodule

`default_nettype wire

// File: rtl/core/dqb_checker.sv
// Port-level checks for the DCT quantizer, bound to the top level.
`default_nettype none

module dqb_checker (
  input wire logic                                    clk,
  input wire logic                                    rst,
  input wire logic                                    in_valid,
  input wire logic                                    in_stall,
  input wire logic                                    out_valid,
  input wire logic                                    out_stall,
  input wire logic signed [dqb_pkg::COEF_WIDTH-1:0]   coefficient,
  input wire logic [dqb_pkg::POS_WIDTH-1:0]           position,
  input wire logic                                    last_of_block
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(coefficient) && $stable(position)
      && $stable(last_of_block))
    else $error("stalled output beat changed");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("input open while a coefficient is shown");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_block |-> position == {dqb_pkg::POS_WIDTH{1'b1}})
    else $error("last flag away from final position");

  a_mid_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_block |=> in_stall)
    else $error("input reopened before block finished");

  a_reopen: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_of_block |=> !in_stall && !out_valid)
    else $error("input not reopened after final coefficient");

endmodule

bind dct8x8_quantize_block dqb_checker u_dqb_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .coefficient   (coefficient),
  .position      (position),
  .last_of_block (last_of_block)
);

`default_nettype wire
